### sv/scc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_pkg: shared types and constants for the sphere collision test
// Holds the sequencer states, the command of the shared root/divide unit
// and the control group of the sum-of-squares unit.
// ----------------------------------------------------------------------------
package scc_pkg;

	localparam int unsigned SQRT_STEPS = 32;	// one root bit per step, 64-bit radicand
	localparam int unsigned DIV_STEPS  = 17;	// quotient never exceeds 2^16

	typedef enum logic {
		OP_SQRT,
		OP_DIV
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic clr;
		logic vld;
	} sq_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQ,
		ST_SQW,
		ST_DIST,
		ST_NORM,
		ST_SHL,
		ST_SQN,
		ST_SQNW,
		ST_LEN,
		ST_DIVS,
		ST_DIVW,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

### sv/scc_sumsq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_sumsq: squaring multiplier with accumulator
// Squares one operand per cycle through a registered multiplier and adds
// the products into a 64-bit sum.
// ----------------------------------------------------------------------------
module scc_sumsq (
	input  logic             clk,
	input  logic             arst_n,
	input  scc_pkg::sq_ctl_t ctl,
	input  logic [30:0]      opnd,
	output logic [63:0]      acc
);
	import scc_pkg::*;

	logic [61:0] prod_s1;
	logic        pv_s1;
	logic [63:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= opnd * opnd;
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + {2'b00, prod_s1};
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

### sv/scc_sqdiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scc_sqdiv: shared iterative root and divide unit
// One compare-subtract datapath serves both a bitwise integer square root
// (two radicand bits per step) and a restoring division (one bit per step).
// ----------------------------------------------------------------------------
module scc_sqdiv (
	input  logic          clk,
	input  logic          arst_n,
	input  scc_pkg::cmd_t cmd,
	input  logic [63:0]   src,
	input  logic [32:0]   rem0,
	input  logic [31:0]   den,
	output logic [31:0]   res,
	output logic          done
);
	import scc_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	op_t         op_q;
	logic [32:0] rem_q;
	logic [63:0] src_q;
	logic [31:0] res_q;
	logic [31:0] den_q;
	logic [34:0] shifted;
	logic [34:0] trial;
	logic [34:0] diff;
	logic        ge;

	always_comb begin
		unique case (op_q)
			OP_SQRT: begin
				shifted = {rem_q, src_q[63:62]};
				trial   = {1'b0, res_q, 2'b01};
			end
			OP_DIV: begin
				shifted = {1'b0, rem_q, src_q[63]};
				trial   = {3'b000, den_q};
			end
		endcase
		ge   = shifted >= trial;
		diff = shifted - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_SQRT;
		end else begin
			done_q <= busy_q && (cnt_q == '0) && !cmd.start;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q   <= cmd.op;
				cnt_q  <= (cmd.op == OP_SQRT) ? 5'(SQRT_STEPS - 1) : 5'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// remainder, shift-in bits and partial result
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			rem_q <= rem0;
			src_q <= src;
			res_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[32:0] : shifted[32:0];
			src_q <= (op_q == OP_SQRT) ? {src_q[61:0], 2'b00} : {src_q[62:0], 1'b0};
			res_q <= {res_q[30:0], ge};
		end
	end

	assign res  = res_q;
	assign done = done_q;

endmodule
`default_nettype wire

### sv/sphere_collision_test.sv
`default_nettype none
// A reference item is taken while idle and gives no result.
// A tested item whose centers are far apart goes from ST_DIFF straight to the result,
// a miss is found by the distance root, and a hit with distinct positions also takes the length root and divides.
// One item at a time: the next item is taken the cycle after the result leaves,
// and the 32-step roots and 17-step divides of the shared unit set how soon that is.
// Reset: arst_n clears the sequencer and the reference sphere (origin, radius 0).
// ----------------------------------------------------------------------------
// sphere_collision_test: sphere against sphere intersection test
// Stores a reference sphere and tests later spheres against it in signed
// Q16.16: hit flag, penetration depth and unit normal toward the reference.
// ----------------------------------------------------------------------------
module sphere_collision_test (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               is_reference,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic signed [31:0] offset_z,
	input  logic        [29:0] radius,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic        [30:0] depth,
	output logic signed [17:0] normal_x,
	output logic signed [17:0] normal_y,
	output logic signed [17:0] normal_z
);
	import scc_pkg::*;

	state_t state_q, state_d;

	// reference sphere: body position and absolute center
	logic [31:0] refpos_q [3];
	logic [32:0] refcen_q [3];
	logic [29:0] refrad_q;

	// tested sphere and working values
	logic [31:0] pos_q [3];
	logic [32:0] cen_q [3];
	logic [30:0] sum_q;
	logic [30:0] md_q  [3];
	logic [31:0] a_q   [3];
	logic        sgn_q [3];
	logic        far_q;
	logic [31:0] m_q;
	logic [31:0] len_q;
	logic [2:0]  cnt_q;

	// result registers
	logic               hit_q;
	logic        [30:0] depth_q;
	logic signed [17:0] norm_q [3];

	logic [31:0] in_pos [3];
	logic [31:0] in_off [3];
	logic [32:0] in_cen [3];
	logic        accept;
	logic [1:0]  idx;
	logic        last;

	logic [33:0] d_c;
	logic [33:0] md_c;
	logic        far_c;
	logic [32:0] n_c;
	logic [32:0] a_c;
	logic [31:0] m01_c;
	logic [31:0] m_c;
	logic [4:0]  sh_c;
	logic [31:0] lim_c;
	logic        small_c;
	logic [17:0] q_c;

	cmd_t        cmd;
	sq_ctl_t     sq_ctl;
	logic [30:0] sq_opnd;
	logic [63:0] acc;
	logic [63:0] u_src;
	logic [32:0] u_rem0;
	logic [31:0] u_res;
	logic        u_done;

	assign in_pos[0] = pos_x;
	assign in_pos[1] = pos_y;
	assign in_pos[2] = pos_z;
	assign in_off[0] = offset_x;
	assign in_off[1] = offset_y;
	assign in_off[2] = offset_z;

	// absolute centers of the incoming sphere, 33-bit exact
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			in_cen[i] = {in_pos[i][31], in_pos[i]} + {in_off[i][31], in_off[i]};
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign idx      = cnt_q[1:0];
	assign last     = (cnt_q == 3'd2);

	// per-axis center difference and position difference of one axis
	always_comb begin
		d_c   = {refcen_q[idx][32], refcen_q[idx]} - {cen_q[idx][32], cen_q[idx]};
		md_c  = d_c[33] ? (34'd0 - d_c) : d_c;
		far_c = |md_c[33:31];
		n_c   = {refpos_q[idx][31], refpos_q[idx]} - {pos_q[idx][31], pos_q[idx]};
		a_c   = n_c[32] ? (33'd0 - n_c) : n_c;
	end

	// largest magnitude of the normal vector
	always_comb begin
		m01_c = (a_q[0] > a_q[1]) ? a_q[0] : a_q[1];
		m_c   = (m01_c > a_q[2]) ? m01_c : a_q[2];
	end

	// left normalization as a binary search: 16, 8, 4, 2, 1
	always_comb begin
		unique case (cnt_q)
			3'd0: begin
				sh_c  = 5'd16;
				lim_c = 32'h0000_8000;
			end
			3'd1: begin
				sh_c  = 5'd8;
				lim_c = 32'h0080_0000;
			end
			3'd2: begin
				sh_c  = 5'd4;
				lim_c = 32'h0800_0000;
			end
			3'd3: begin
				sh_c  = 5'd2;
				lim_c = 32'h2000_0000;
			end
			3'd4: begin
				sh_c  = 5'd1;
				lim_c = 32'h4000_0000;
			end
			default: begin
				sh_c  = 5'd0;
				lim_c = 32'h0000_0000;
			end
		endcase
		small_c = m_q < lim_c;
	end

	assign q_c = {1'b0, u_res[16:0]};

	// ------------------------------------------------------------------------
	// Sequencer: next state and strobes to the shared units
	// ------------------------------------------------------------------------
	always_comb begin
		state_d    = state_q;
		cmd.start  = 1'b0;
		cmd.op     = OP_SQRT;
		sq_ctl.clr = 1'b0;
		sq_ctl.vld = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !is_reference) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				sq_ctl.clr = 1'b1;
				if (last) begin
					// a center gap of 2^31 or more can never touch
					state_d = (far_q || far_c) ? ST_OUT : ST_SQ;
				end
			end
			ST_SQ: begin
				sq_ctl.vld = 1'b1;
				if (last) begin
					state_d = ST_SQW;
				end
			end
			ST_SQW: begin
				// hold in ST_SQW until the last product has landed in the sum
				if (cnt_q[0]) begin
					cmd.start = 1'b1;
					state_d   = ST_DIST;
				end
			end
			ST_DIST: begin
				if (u_done) begin
					state_d = (u_res >= {1'b0, sum_q}) ? ST_OUT : ST_NORM;
				end
			end
			ST_NORM: begin
				// coinciding positions: keep the zero normal
				state_d = (m_c == '0) ? ST_OUT : ST_SHL;
			end
			ST_SHL: begin
				sq_ctl.clr = 1'b1;
				if (cnt_q == 3'd4) begin
					state_d = ST_SQN;
				end
			end
			ST_SQN: begin
				sq_ctl.vld = 1'b1;
				if (last) begin
					state_d = ST_SQNW;
				end
			end
			ST_SQNW: begin
				if (cnt_q[0]) begin
					cmd.start = 1'b1;
					state_d   = ST_LEN;
				end
			end
			ST_LEN: begin
				if (u_done) begin
					state_d = ST_DIVS;
				end
			end
			ST_DIVS: begin
				cmd.start = 1'b1;
				cmd.op    = OP_DIV;
				state_d   = ST_DIVW;
			end
			ST_DIVW: begin
				if (u_done) begin
					state_d = last ? ST_OUT : ST_DIVS;
				end
			end
			ST_OUT: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_DIVS: cnt_q <= cnt_q;
				ST_DIVW: begin
					// advance the axis only when its quotient is in
					if (u_done) begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				default: cnt_q <= (state_d != state_q) ? 3'd0 : cnt_q + 3'd1;
			endcase
		end
	end

	// reference sphere: cleared by reset, replaced by a reference item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				refpos_q[i] <= '0;
				refcen_q[i] <= '0;
			end
			refrad_q <= '0;
		end else if (accept && is_reference) begin
			for (int i = 0; i < 3; i++) begin
				refpos_q[i] <= in_pos[i];
				refcen_q[i] <= in_cen[i];
			end
			refrad_q <= radius;
		end
	end

	// ------------------------------------------------------------------------
	// Working and result registers
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !is_reference) begin
					for (int i = 0; i < 3; i++) begin
						pos_q[i]  <= in_pos[i];
						cen_q[i]  <= in_cen[i];
						norm_q[i] <= '0;
					end
					sum_q   <= {1'b0, refrad_q} + {1'b0, radius};
					far_q   <= 1'b0;
					hit_q   <= 1'b0;
					depth_q <= '0;
				end
			end
			ST_DIFF: begin
				md_q[idx]  <= md_c[30:0];
				a_q[idx]   <= a_c[31:0];
				sgn_q[idx] <= n_c[32];
				far_q      <= far_q | far_c;
			end
			ST_DIST: begin
				if (u_done && (u_res < {1'b0, sum_q})) begin
					hit_q   <= 1'b1;
					depth_q <= sum_q - u_res[30:0];
				end
			end
			ST_NORM: begin
				// bring the largest magnitude below 2^31
				if (m_c[31]) begin
					m_q <= m_c >> 1;
					for (int i = 0; i < 3; i++) begin
						a_q[i] <= a_q[i] >> 1;
					end
				end else begin
					m_q <= m_c;
				end
			end
			ST_SHL: begin
				if (small_c) begin
					m_q <= m_q << sh_c;
					for (int i = 0; i < 3; i++) begin
						a_q[i] <= a_q[i] << sh_c;
					end
				end
			end
			ST_LEN: begin
				if (u_done) begin
					len_q <= u_res;
				end
			end
			ST_DIVW: begin
				if (u_done) begin
					norm_q[idx] <= sgn_q[idx] ? (18'sd0 - $signed(q_c)) : $signed(q_c);
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Shared units
	// ------------------------------------------------------------------------
	assign sq_opnd = (state_q == ST_SQN) ? a_q[idx][30:0] : md_q[idx];

	scc_sumsq u_sumsq (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (sq_ctl),
		.opnd   (sq_opnd),
		.acc    (acc)
	);

	// divide: remainder starts at a >> 1, then a[0] and sixteen zeros shift in
	assign u_src  = (state_q == ST_DIVS) ? {a_q[idx][0], 63'd0} : acc;
	assign u_rem0 = (state_q == ST_DIVS) ? {2'b00, a_q[idx][31:1]} : 33'd0;

	scc_sqdiv u_sqdiv (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.src    (u_src),
		.rem0   (u_rem0),
		.den    (len_q),
		.res    (u_res),
		.done   (u_done)
	);

	assign out_valid = (state_q == ST_OUT);
	assign hit       = hit_q;
	assign depth     = depth_q;
	assign normal_x  = norm_q[0];
	assign normal_y  = norm_q[1];
	assign normal_z  = norm_q[2];

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_hit_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> depth != '0)
		else $error("hit with zero depth");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> depth == '0 && normal_x == '0 && normal_y == '0 && normal_z == '0)
		else $error("miss with nonzero depth or normal");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normal_x <= 18'sd65536 && normal_x >= -18'sd65536
			&& normal_y <= 18'sd65536 && normal_y >= -18'sd65536
			&& normal_z <= 18'sd65536 && normal_z >= -18'sd65536)
		else $error("normal component outside unit range");

	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> state_q == ST_DIST || state_q == ST_LEN || state_q == ST_DIVW)
		else $error("shared unit finished while sequencer not waiting");

endmodule
`default_nettype wire
